// ----- rtl/core/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha_pkg;

    // One message byte as it arrives on the input channel.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       end_of_message;
    } msg_t;

    // One word of the final hash value.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // What the block being compressed is made of.
    typedef enum logic [1:0] {
        BLK_DATA,    // sixteen message words
        BLK_PAD,     // message words, the 0x80 marker, zeros
        BLK_PADLEN,  // as above, with the bit length in the last two words
        BLK_LEN      // zeros and the bit length only
    } blk_kind_t;

    localparam int WORDS      = 16;
    localparam int LEN_HI_IDX = 14;
    localparam int LEN_LO_IDX = 15;
    localparam logic [5:0] PAD_LIMIT = 6'd56;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ----- rtl/core/sha_ram.sv -----
// ----------------------------------------------------------------------------
// sha_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/sha256_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha256_message_digest
// SHA-256 digest of a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// A byte transfer is taken while the block is idle; every fourth byte is
// written as a big-endian word into a 16-word block RAM. When a block fills,
// or at end of message, the block stalls its input while it compresses the
// block: the load streams the RAM (one read a cycle, through its registered
// read port) into the message schedule window, the 64 rounds run one a
// cycle, and the update folds the working words into the chaining value. An
// end of message compresses one or two padded blocks, then offers the eight
// digest words, one a cycle unless stalled, before the next message starts.
module sha256_message_digest (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::msg_t    msg,
    input  logic             msg_valid,
    output logic             msg_stall,
    output sha_pkg::digest_t digest,
    output logic             digest_valid,
    input  logic             digest_stall
);

    sha_pkg::state_t    state_reg, state_next;
    sha_pkg::blk_kind_t kind_reg, kind_next;
    logic               endp_reg, endp_next;
    logic [5:0]         fill_reg, fill_next;
    logic [63:0]        len_reg, len_next;
    logic [31:0]        part_reg, part_next;
    logic [4:0]         ld_cnt_reg, ld_cnt_next;
    logic [5:0]         rnd_reg, rnd_next;
    logic [2:0]         idx_reg, idx_next;
    logic [31:0]        chain_reg [8];
    logic [31:0]        chain_next [8];
    logic [31:0]        v_reg [8];
    logic [31:0]        v_next [8];
    logic [31:0]        win_reg [16];
    logic [31:0]        win_next [16];

    logic               ram_we;
    logic [3:0]         ram_waddr;
    logic [31:0]        ram_wdata;
    logic [3:0]         ram_raddr;
    logic [31:0]        ram_rdata;

    logic               in_xfer;
    logic               out_xfer;
    logic [31:0]        ins_word;
    logic [31:0]        pad_word;
    logic [3:0]         cap_idx;
    logic [31:0]        cap_word;
    logic [31:0]        sched_word;
    logic [31:0]        tmp1;
    logic [31:0]        tmp2;
    logic [5:0]         fill_after;

    sha_ram #(
        .WIDTH (32),
        .DEPTH (sha_pkg::WORDS)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes and output payload.
    assign msg_stall           = (state_reg != sha_pkg::ST_IDLE);
    assign in_xfer             = msg_valid && !msg_stall;
    assign digest_valid        = (state_reg == sha_pkg::ST_OUT);
    assign out_xfer            = digest_valid && !digest_stall;
    assign digest.digest_word  = chain_reg[idx_reg];
    assign digest.word_index   = idx_reg;
    assign digest.last_word    = (idx_reg == 3'd7);

    // Byte placement and the padding word of the current partial word.
    assign ins_word = {msg.data_byte, 24'h0} >> {fill_reg[1:0], 3'b000};
    assign pad_word = ((fill_reg[1:0] == 2'd0) ? 32'h0 : part_reg)
                    | ({sha_pkg::PAD_BYTE, 24'h0} >> {fill_reg[1:0], 3'b000});
    assign fill_after = msg.has_data ? 6'(fill_reg + 6'd1) : fill_reg;

    // RAM ports: bytes complete words during idle, loads read in order.
    assign ram_we    = in_xfer && msg.has_data && (fill_reg[1:0] == 2'd3);
    assign ram_waddr = fill_reg[5:2];
    assign ram_wdata = part_reg | ins_word;
    assign ram_raddr = ld_cnt_reg[3:0];

    // Word captured into the schedule window, chosen by block kind.
    assign cap_idx = 4'(ld_cnt_reg - 5'd1);
    always_comb
    begin
        cap_word = 32'h0;
        case (kind_reg)
            sha_pkg::BLK_DATA:
            begin
                cap_word = ram_rdata;
            end
            sha_pkg::BLK_PAD, sha_pkg::BLK_PADLEN:
            begin
                if (cap_idx < fill_reg[5:2])
                begin
                    cap_word = ram_rdata;
                end
                else if (cap_idx == fill_reg[5:2])
                begin
                    cap_word = pad_word;
                end
                else if (kind_reg == sha_pkg::BLK_PADLEN && cap_idx == 4'(sha_pkg::LEN_HI_IDX))
                begin
                    cap_word = len_reg[63:32];
                end
                else if (kind_reg == sha_pkg::BLK_PADLEN && cap_idx == 4'(sha_pkg::LEN_LO_IDX))
                begin
                    cap_word = len_reg[31:0];
                end
            end
            sha_pkg::BLK_LEN:
            begin
                if (cap_idx == 4'(sha_pkg::LEN_HI_IDX))
                begin
                    cap_word = len_reg[63:32];
                end
                else if (cap_idx == 4'(sha_pkg::LEN_LO_IDX))
                begin
                    cap_word = len_reg[31:0];
                end
            end
            default:
            begin
                cap_word = 32'h0;
            end
        endcase
    end

    // Round arithmetic and next schedule word.
    assign sched_word = win_reg[0] + sha_pkg::small_sig0(win_reg[1]) + win_reg[9]
                      + sha_pkg::small_sig1(win_reg[14]);
    assign tmp1 = v_reg[7] + sha_pkg::big_sig1(v_reg[4])
                + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
                + sha_pkg::ROUND_K[rnd_reg] + win_reg[0];
    assign tmp2 = sha_pkg::big_sig0(v_reg[0])
                + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Sequencer: next state and datapath updates.
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        endp_next   = endp_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        part_next   = part_reg;
        ld_cnt_next = ld_cnt_reg;
        rnd_next    = rnd_reg;
        idx_next    = idx_reg;
        chain_next  = chain_reg;
        v_next      = v_reg;
        win_next    = win_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (msg.has_data)
                    begin
                        part_next = (fill_reg[1:0] == 2'd0) ? ins_word : (part_reg | ins_word);
                        fill_next = fill_after;
                        len_next  = len_reg + 64'd8;
                    end
                    ld_cnt_next = 5'd0;
                    if (msg.has_data && fill_reg == 6'd63)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        kind_next  = sha_pkg::BLK_DATA;
                        endp_next  = msg.end_of_message;
                    end
                    else if (msg.end_of_message)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        kind_next  = (fill_after >= sha_pkg::PAD_LIMIT) ?
                                     sha_pkg::BLK_PAD : sha_pkg::BLK_PADLEN;
                        endp_next  = 1'b0;
                    end
                end
            end
            sha_pkg::ST_LOAD:
            begin
                ld_cnt_next = ld_cnt_reg + 5'd1;
                if (ld_cnt_reg != 5'd0)
                begin
                    for (int j = 0; j < 15; j++)
                    begin
                        win_next[j] = win_reg[j + 1];
                    end
                    win_next[15] = cap_word;
                end
                if (ld_cnt_reg == 5'd16)
                begin
                    state_next = sha_pkg::ST_ROUND;
                    rnd_next   = 6'd0;
                    v_next     = chain_reg;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                for (int j = 0; j < 15; j++)
                begin
                    win_next[j] = win_reg[j + 1];
                end
                win_next[15] = sched_word;
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + tmp1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = tmp1 + tmp2;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_UPDATE;
                end
            end
            sha_pkg::ST_UPDATE:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    chain_next[j] = chain_reg[j] + v_reg[j];
                end
                ld_cnt_next = 5'd0;
                case (kind_reg)
                    sha_pkg::BLK_DATA:
                    begin
                        if (endp_reg)
                        begin
                            state_next = sha_pkg::ST_LOAD;
                            kind_next  = sha_pkg::BLK_PADLEN;
                            endp_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = sha_pkg::ST_IDLE;
                        end
                    end
                    sha_pkg::BLK_PAD:
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        kind_next  = sha_pkg::BLK_LEN;
                    end
                    default:
                    begin
                        state_next = sha_pkg::ST_OUT;
                        idx_next   = 3'd0;
                    end
                endcase
            end
            sha_pkg::ST_OUT:
            begin
                if (out_xfer)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        state_next = sha_pkg::ST_IDLE;
                        chain_next = sha_pkg::INIT_HASH;
                        fill_next  = 6'd0;
                        len_next   = 64'd0;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and chaining state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_IDLE;
            kind_reg   <= sha_pkg::BLK_DATA;
            endp_reg   <= 1'b0;
            fill_reg   <= 6'd0;
            len_reg    <= 64'd0;
            ld_cnt_reg <= 5'd0;
            rnd_reg    <= 6'd0;
            idx_reg    <= 3'd0;
            chain_reg  <= sha_pkg::INIT_HASH;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            endp_reg   <= endp_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            ld_cnt_reg <= ld_cnt_next;
            rnd_reg    <= rnd_next;
            idx_reg    <= idx_next;
            chain_reg  <= chain_next;
        end
    end

    // Working words, schedule window and partial word.
    always_ff @(posedge clk)
    begin
        part_reg <= part_next;
        v_reg    <= v_next;
        win_reg  <= win_next;
    end

endmodule

// ----- rtl/core/sha_checker.sv -----
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks on the SHA-256 digest block, bound to its top level.
// ----------------------------------------------------------------------------
module sha_checker (
    input logic             clk,
    input logic             rst_n,
    input sha_pkg::msg_t    msg,
    input logic             msg_valid,
    input logic             msg_stall,
    input sha_pkg::digest_t digest,
    input logic             digest_valid,
    input logic             digest_stall
);

    // A stalled digest word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid && $stable(digest))
    else $error("digest changed while stalled");

    // The last flag marks exactly the eighth word.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == 3'd7)))
    else $error("last_word does not match word_index");

    // Digest words follow one another without gaps.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_stall && !digest.last_word |=>
        digest_valid && digest.word_index == 3'($past(digest.word_index) + 3'd1))
    else $error("digest word sequence broken");

    // No byte is taken while the digest is being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> msg_stall)
    else $error("input taken during digest output");

endmodule

bind sha256_message_digest sha_checker u_sha_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg          (msg),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .digest       (digest),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall)
);
